[hdl/mtg_pkg.sv]
package mtg_pkg;

  localparam int TABLE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = $clog2(TABLE_DEPTH + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MT_MATRIX    = 32'h9908B0DF;
  localparam word_t MT_INIT_MULT = 32'd1812433253;
  localparam word_t MT_TEMPER_B  = 32'h9D2C5680;
  localparam word_t MT_TEMPER_C  = 32'hEFC60000;

  localparam idx_t IDX_DEPTH  = idx_t'(TABLE_DEPTH);
  localparam idx_t IDX_LAST   = idx_t'(TABLE_DEPTH - 1);
  localparam idx_t IDX_LAST2  = idx_t'(TABLE_DEPTH - 2);
  localparam idx_t IDX_OFFSET = idx_t'(TWIST_OFFSET);
  localparam idx_t IDX_WRAP   = idx_t'(TABLE_DEPTH - TWIST_OFFSET);

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  // commands from the controller, one step per cycle; a done flag rides with the last step
  typedef struct packed {
    logic load_seed;
    logic seed_mul;
    logic seed_add;
    logic seed_done;
    logic tw_start;
    logic tw_first;
    logic tw_far;
    logic tw_step;
    logic tw_done;
    logic out_read;
    logic out_word;
    logic out_unseeded;
  } mtg_cmd_t;

  typedef struct packed {
    logic seeded;
    logic idx_full;
    logic k_last;
  } mtg_sts_t;

endpackage

[hdl/mtg_ram.sv]
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mtg_ctrl.sv]
module mtg_ctrl import mtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      req_type,
  input  mtg_sts_t  sts,
  output mtg_cmd_t  cmd,
  output logic      busy,
  output logic      strobe
);

  typedef enum logic [3:0] {
    IDLE,
    SEED_MUL,
    SEED_ADD,
    TW_START,
    TW_FIRST,
    TW_FAR,
    TW_STEP,
    OUT_READ,
    OUT_WORD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != IDLE);
  assign accept = start && (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          if (req_type == REQ_SEED) begin
            cmd.load_seed = 1'b1;
            state_next    = SEED_MUL;
          end else if (!sts.seeded) begin
            cmd.out_unseeded = 1'b1;
          end else if (sts.idx_full) begin
            state_next = TW_START;
          end else begin
            state_next = OUT_READ;
          end
        end
      end
      SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = SEED_ADD;
      end
      SEED_ADD: begin
        cmd.seed_add = 1'b1;
        if (sts.k_last) begin
          cmd.seed_done = 1'b1;
          state_next    = IDLE;
        end else begin
          state_next = SEED_MUL;
        end
      end
      TW_START: begin
        cmd.tw_start = 1'b1;
        state_next   = TW_FIRST;
      end
      TW_FIRST: begin
        cmd.tw_first = 1'b1;
        state_next   = TW_FAR;
      end
      TW_FAR: begin
        cmd.tw_far = 1'b1;
        state_next = TW_STEP;
      end
      TW_STEP: begin
        cmd.tw_step = 1'b1;
        if (sts.k_last) begin
          cmd.tw_done = 1'b1;
          state_next  = OUT_READ;
        end else begin
          state_next = TW_FAR;
        end
      end
      OUT_READ: begin
        cmd.out_read = 1'b1;
        state_next   = OUT_WORD;
      end
      OUT_WORD: begin
        cmd.out_word = 1'b1;
        state_next   = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.out_word || cmd.out_unseeded;
    end
  end

  a_seed_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_SEED)) |=> busy)
    else $error("seed transfer did not start the fill");

  a_unseeded_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_NEXT) && !sts.seeded) |=> (strobe && !busy))
    else $error("unseeded request did not answer next cycle");

  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(cmd.out_word || cmd.out_unseeded))
    else $error("result strobe without a result load");

  a_twist_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.tw_done |=> cmd.out_read)
    else $error("twist end not followed by the word read");

endmodule

[hdl/mtg_datapath.sv]
module mtg_datapath import mtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mtg_cmd_t  cmd,
  input  word_t     seed_value,
  output mtg_sts_t  sts,
  output word_t     random_word,
  output logic      not_seeded
);

  idx_t  k;
  idx_t  idx;
  logic  seeded;
  word_t prev;
  word_t prod;
  word_t cur;
  word_t nxt;

  logic  we;
  idx_t  raddr;
  word_t wdata;
  word_t rdata;
  word_t sum;
  word_t mix;
  word_t twist_word;
  idx_t  far_addr;
  idx_t  skip_addr;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_TEMPER_B);
    y = y ^ ((y << 15) & MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign sum = prod + {{(WORD_W-IDX_W){1'b0}}, k};

  // twist: upper bit of entry k, lower bits of entry k+1, far word from the read port
  assign mix        = {cur[WORD_W-1], nxt[WORD_W-2:0]};
  assign twist_word = rdata ^ {1'b0, mix[WORD_W-1:1]} ^ (mix[0] ? MT_MATRIX : '0);

  assign far_addr  = (k < IDX_WRAP) ? (k + IDX_OFFSET) : (k - IDX_WRAP);
  assign skip_addr = (k >= IDX_LAST2) ? (k - IDX_LAST2) : (k + idx_t'(2));

  always_comb begin
    if (cmd.tw_first) begin
      raddr = idx_t'(1);
    end else if (cmd.tw_far) begin
      raddr = far_addr;
    end else if (cmd.tw_step) begin
      raddr = skip_addr;
    end else if (cmd.out_read) begin
      raddr = idx;
    end else begin
      raddr = '0;
    end
  end

  assign we = cmd.seed_mul || cmd.seed_add || cmd.tw_step;

  always_comb begin
    if (cmd.seed_mul) begin
      wdata = prev;
    end else if (cmd.seed_add) begin
      wdata = sum;
    end else begin
      wdata = twist_word;
    end
  end

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(k[$clog2(TABLE_DEPTH)-1:0]),
    .wdata(wdata),
    .raddr(raddr[$clog2(TABLE_DEPTH)-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      idx    <= IDX_DEPTH;
      seeded <= 1'b0;
    end else begin
      if (cmd.load_seed || cmd.tw_start) begin
        k <= '0;
      end else if (cmd.seed_mul || cmd.tw_step) begin
        k <= k + idx_t'(1);
      end
      if (cmd.seed_done) begin
        idx    <= IDX_DEPTH;
        seeded <= 1'b1;
      end else if (cmd.tw_done) begin
        idx <= '0;
      end else if (cmd.out_word) begin
        idx <= idx + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      prev <= seed_value;
    end else if (cmd.seed_add) begin
      prev <= sum;
    end
    if (cmd.seed_mul) begin
      prod <= (prev ^ (prev >> 30)) * MT_INIT_MULT;
    end
    if (cmd.tw_first) begin
      cur <= rdata;
    end else if (cmd.tw_step) begin
      cur <= nxt;
    end
    if (cmd.tw_far) begin
      nxt <= rdata;
    end
    if (cmd.out_word) begin
      random_word <= temper(rdata);
      not_seeded  <= 1'b0;
    end else if (cmd.out_unseeded) begin
      random_word <= '0;
      not_seeded  <= 1'b1;
    end
  end

  assign sts.seeded   = seeded;
  assign sts.idx_full = (idx == IDX_DEPTH);
  assign sts.k_last   = (k == IDX_LAST);

  a_seed_sets_index: assert property (@(posedge clk) disable iff (rst)
    cmd.seed_done |=> (seeded && (idx == IDX_DEPTH)))
    else $error("seed end did not set index and seeded flag");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_read |-> (idx < IDX_DEPTH))
    else $error("word read with index past the table");

endmodule

[hdl/mersenne_twister_generator.sv]
// MT19937 32-bit random word generator.
// command channel: a request transfers on a rising edge with start high and
// busy low. req_type 0 reseeds from seed_value and gives no result; req_type 1
// asks for the next tempered word.
// result channel: random_word and not_seeded are valid for the single cycle
// in which strobe is high; the receiver cannot stall it, so it must sample then.
// from the request edge to strobe, a plain next request passes the OUT_READ and
// OUT_WORD states; when the table is used up a twist runs first (the twist walks
// the table with a far read state and a write state per entry on one write and
// one read port of the table RAM); a next request before any seed answers in
// the following cycle with zero and not_seeded set. a reseed keeps busy high
// for a multiply step and an add step for each entry after the first. no new
// request is taken until busy drops, as the single table RAM is shared.
// reset clears the controller, sets the table index to full and marks the
// generator unseeded; the table contents are unknown until the first seed.
module mersenne_twister_generator import mtg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  logic  req_type,
  input  word_t seed_value,
  output logic  strobe,
  output word_t random_word,
  output logic  not_seeded
);

  mtg_cmd_t cmd;
  mtg_sts_t sts;

  mtg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy),
    .strobe  (strobe)
  );

  mtg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .seed_value (seed_value),
    .sts        (sts),
    .random_word(random_word),
    .not_seeded (not_seeded)
  );

endmodule

[tb/sv/mtg_checker.sv]
`timescale 1ns / 100ps

module mtg_checker import mtg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  logic  req_type,
  input  word_t seed_value,
  input  logic  strobe,
  input  word_t random_word,
  input  logic  not_seeded,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count,
  output int    twist_count
);

  localparam word_t TOP_BIT  = 32'h80000000;
  localparam word_t LOW_BITS = 32'h7FFFFFFF;

  typedef struct packed {
    word_t word;
    logic  unseeded;
  } draw_t;

  word_t mt_words [TABLE_DEPTH];
  int    word_pos;
  bit    have_seed;
  draw_t expected_draws [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    twist_count   = 0;
    word_pos      = TABLE_DEPTH;
    have_seed     = 1'b0;
  end

  task automatic load_table(input word_t seed);
    word_t prev;
    mt_words[0] = seed;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      prev        = mt_words[k-1];
      mt_words[k] = MT_INIT_MULT * (prev ^ (prev >> 30)) + word_t'(k);
    end
    word_pos = TABLE_DEPTH;
  endtask

  // in-place regeneration, later entries see already updated earlier ones
  task automatic regenerate_table();
    word_t mix;
    word_t sh;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      mix = (mt_words[k] & TOP_BIT) | (mt_words[(k + 1) % TABLE_DEPTH] & LOW_BITS);
      sh  = mix >> 1;
      if (mix[0]) begin
        sh = sh ^ MT_MATRIX;
      end
      mt_words[k] = mt_words[(k + TWIST_OFFSET) % TABLE_DEPTH] ^ sh;
    end
    word_pos = 0;
    twist_count++;
  endtask

  function automatic word_t temper_word(input word_t y);
    word_t t;
    t = y ^ (y >> 11);
    t = t ^ ((t << 7) & MT_TEMPER_B);
    t = t ^ ((t << 15) & MT_TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  task automatic predict_next(output draw_t d);
    if (!have_seed) begin
      d.word     = '0;
      d.unseeded = 1'b1;
    end else begin
      if (word_pos >= TABLE_DEPTH) begin
        regenerate_table();
      end
      d.word     = temper_word(mt_words[word_pos]);
      d.unseeded = 1'b0;
      word_pos++;
    end
  endtask

  always @(posedge clk) begin
    draw_t want;
    draw_t next_draw;
    if (rst) begin
      word_pos  = TABLE_DEPTH;
      have_seed = 1'b0;
      expected_draws.delete();
    end else begin
      // retire the result first, a transfer in this same cycle cannot own it
      if (strobe) begin
        if (expected_draws.size() == 0) begin
          $error("unexpected result: random_word %h not_seeded %b", random_word, not_seeded);
          fail_count++;
        end else begin
          want = expected_draws.pop_front();
          checked_count++;
          if (random_word !== want.word) begin
            $error("random_word mismatch: expected %h, got %h", want.word, random_word);
            fail_count++;
          end
          if (not_seeded !== want.unseeded) begin
            $error("not_seeded mismatch: expected %b, got %b", want.unseeded, not_seeded);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (req_type == REQ_SEED) begin
          load_table(seed_value);
          have_seed = 1'b1;
        end else begin
          predict_next(next_draw);
          expected_draws.push_back(next_draw);
        end
      end
    end
    pending_count = expected_draws.size();
  end

endmodule

[tb/sv/mersenne_twister_generator_tb.sv]
`timescale 1ns / 100ps

module mersenne_twister_generator_tb import mtg_pkg::*;;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  logic  req_type = REQ_NEXT;
  word_t seed_value = '0;
  logic  strobe;
  word_t random_word;
  logic  not_seeded;

  int fail_count;
  int pending_count;
  int checked_count;
  int twist_count;
  int seed_count = 0;
  int draw_count = 0;
  bit quiet_run = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mersenne_twister_generator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .seed_value  (seed_value),
    .strobe      (strobe),
    .random_word (random_word),
    .not_seeded  (not_seeded)
  );

  mtg_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .seed_value    (seed_value),
    .strobe        (strobe),
    .random_word   (random_word),
    .not_seeded    (not_seeded),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .twist_count   (twist_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t pick_seed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  // hold start until the transfer, then drop it only if a gap follows
  task automatic issue(input logic kind, input word_t seed, input int gap);
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= kind;
    seed_value <= seed;
    do @(posedge clk); while (busy);
    if (kind == REQ_SEED) begin
      seed_count++;
    end else begin
      draw_count++;
    end
    if (gap > 0) begin
      @(negedge clk);
      start      <= 1'b0;
      seed_value <= $urandom();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int run_len;
    int run_target;
    int sent;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // requests before any seed, seed field ignored
    issue(REQ_NEXT, '1, 0);
    issue(REQ_NEXT, '0, 2);
    issue(REQ_SEED, '0, 0);
    repeat (3) issue(REQ_NEXT, '1, 0);
    issue(REQ_SEED, '1, 1);
    repeat (3) issue(REQ_NEXT, '0, pick_gap());
    issue(REQ_SEED, 32'd5489, 0);
    repeat (3) issue(REQ_NEXT, $urandom(), 0);
    issue(REQ_SEED, 32'h80000000, 3);
    repeat (2) issue(REQ_NEXT, $urandom(), 1);
    // back-to-back reseed, the second one wins
    issue(REQ_SEED, 32'h12345678, 0);
    issue(REQ_SEED, 32'h7FFFFFFF, 0);
    repeat (2) issue(REQ_NEXT, $urandom(), 0);

    // first run is long enough to use up the table and regenerate it
    run_len    = 0;
    run_target = 650;
    sent       = 0;
    while (sent < 750) begin
      if (run_len >= run_target) begin
        quiet_run  = ($urandom_range(0, 2) == 0);
        issue(REQ_SEED, pick_seed(), pick_gap());
        run_len    = 0;
        run_target = $urandom_range(1, 40);
      end else begin
        issue(REQ_NEXT, $urandom(), pick_gap());
        run_len++;
      end
      sent++;
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (1400) @(posedge clk);

    $display("covered %0d seed loads and %0d word requests, %0d results checked",
             seed_count, draw_count, checked_count);
    $display("table regenerated %0d times, including a wrap past the last entry",
             twist_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
